/* sv/tmd_pkg.sv */
// tmd_pkg: types, constants and compare helpers of the despeckle filter.
// Used by every module of the block; depends on nothing.
package tmd_pkg;

    localparam int PIX_W      = 16;
    localparam int ROW_W      = 12;
    localparam int SIZE_W     = 13;
    localparam int THR_W      = 16;
    localparam int MAX_HEIGHT = 4096;
    localparam int WIN_N      = 9;
    localparam int CENTRE     = 4;
    localparam int Q_DEPTH    = 4;
    localparam int APB_AW     = 4;
    localparam int APB_DW     = 32;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    typedef logic signed [PIX_W-1:0] t_pix;

    typedef enum logic [1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1,
        REG_THRESHOLD    = 2'd2,
        REG_FORCE        = 2'd3
    } t_reg;

    // window in raster order, win[3*row + col]; a drain carries its pixel at CENTRE
    typedef struct packed {
        t_pix [WIN_N-1:0] win;
        logic             interior;
        logic             frame_end;
    } t_rec;

    typedef struct packed {
        t_pix lo;
        t_pix mid;
        t_pix hi;
    } t_tri;

    function automatic t_pix min2(input t_pix a, input t_pix b);
        return (a < b) ? a : b;
    endfunction

    function automatic t_pix max2(input t_pix a, input t_pix b);
        return (a > b) ? a : b;
    endfunction

    function automatic t_pix min3(input t_pix a, input t_pix b, input t_pix c);
        return min2(min2(a, b), c);
    endfunction

    function automatic t_pix max3(input t_pix a, input t_pix b, input t_pix c);
        return max2(max2(a, b), c);
    endfunction

    function automatic t_pix med3(input t_pix a, input t_pix b, input t_pix c);
        return max2(min2(a, b), min2(max2(a, b), c));
    endfunction

    function automatic t_tri sort3(input t_pix a, input t_pix b, input t_pix c);
        t_tri t;
        t.lo  = min3(a, b, c);
        t.mid = med3(a, b, c);
        t.hi  = max3(a, b, c);
        return t;
    endfunction

endpackage

/* sv/tmd_front.sv */
// tmd_front: item intake, raster counters, two line stores and the 3x3 window.
// Pushes one record per emitted pixel to the queue. Depends on tmd_pkg.
module tmd_front import tmd_pkg::*; #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_op,
    input  t_pix              i_pixel,
    input  logic [SIZE_W-1:0] i_frame_width,
    input  logic [SIZE_W-1:0] i_frame_height,
    output logic              o_push,
    output t_rec              o_rec,
    input  logic              i_pop
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int PW = $clog2(MAX_WIDTH + 2);
    localparam int EW = (PW > SIZE_W) ? PW : SIZE_W;
    localparam int CW = $clog2(Q_DEPTH + 1);
    localparam logic [EW-1:0]     W_MAX = EW'(MAX_WIDTH);
    localparam logic [SIZE_W-1:0] H_MAX = SIZE_W'(MAX_HEIGHT);

    logic [AW-1:0]    r_in_col, n_in_col;
    logic [ROW_W-1:0] r_in_row, n_in_row;
    logic [AW-1:0]    r_out_col, n_out_col;
    logic [ROW_W-1:0] r_out_row, n_out_row;
    logic [PW-1:0]    r_pend, n_pend;
    logic [CW-1:0]    r_credit, n_credit;

    logic          r_s_valid;
    logic          r_s_pix_op;
    logic          r_s_emit;
    logic [AW-1:0] r_s_addr;
    t_pix          r_s_pix;
    logic          r_s_sel_two;
    logic          r_s_interior;
    logic          r_s_fe;

    t_pix r_la_q, r_lta_q;
    logic r_byp_hit;
    t_pix r_byp_la, r_byp_lta;

    t_pix r_win [WIN_N];
    t_pix n_win [WIN_N];

    t_pix r_la_mem  [MAX_WIDTH];
    t_pix r_lta_mem [MAX_WIDTH];

    logic [EW-1:0]     w_eff, pend_x;
    logic [SIZE_W-1:0] h_eff;
    logic              accept, is_drain, pix_emit, drain_emit, emit, sel_two;
    logic              in_col_last, in_row_last, out_col_last, out_row_last;
    logic              interior, fe;
    logic [AW-1:0]     rd_addr;
    logic              wr_en;
    t_pix              la_v, lta_v;

    always_comb begin
        if (i_frame_width == '0) begin
            w_eff = EW'(1);
        end else if (EW'(i_frame_width) > W_MAX) begin
            w_eff = W_MAX;
        end else begin
            w_eff = EW'(i_frame_width);
        end
        if (i_frame_height == '0) begin
            h_eff = SIZE_W'(1);
        end else if (i_frame_height > H_MAX) begin
            h_eff = H_MAX;
        end else begin
            h_eff = i_frame_height;
        end
    end

    assign o_ready      = i_rst_n && (r_credit < CW'(Q_DEPTH));
    assign accept       = i_valid && o_ready;
    assign is_drain     = (i_op == OP_DRAIN);
    assign pend_x       = EW'(r_pend);
    assign pix_emit     = pend_x >= (w_eff + EW'(1));
    assign drain_emit   = (r_pend != '0);
    assign emit         = is_drain ? drain_emit : pix_emit;
    assign sel_two      = pend_x > w_eff;
    assign in_col_last  = (EW'(r_in_col) + EW'(1)) >= w_eff;
    assign in_row_last  = (SIZE_W'(r_in_row) + SIZE_W'(1)) >= h_eff;
    assign out_col_last = (EW'(r_out_col) + EW'(1)) >= w_eff;
    assign out_row_last = (SIZE_W'(r_out_row) + SIZE_W'(1)) >= h_eff;
    assign interior     = (r_out_row != '0) && !out_row_last &&
                          (r_out_col != '0) && !out_col_last;
    assign fe           = out_col_last && out_row_last;
    assign rd_addr      = is_drain ? r_out_col : r_in_col;

    always_comb begin
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        n_pend    = r_pend;
        if (accept) begin
            if (!is_drain) begin
                if (in_col_last) begin
                    n_in_col = '0;
                    n_in_row = in_row_last ? '0 : r_in_row + ROW_W'(1);
                end else begin
                    n_in_col = r_in_col + AW'(1);
                end
                if (!pix_emit) begin
                    n_pend = r_pend + PW'(1);
                end
            end else if (drain_emit) begin
                n_pend = r_pend - PW'(1);
            end
            if (emit) begin
                if (out_col_last) begin
                    n_out_col = '0;
                    n_out_row = out_row_last ? '0 : r_out_row + ROW_W'(1);
                end else begin
                    n_out_col = r_out_col + AW'(1);
                end
            end
        end
        n_credit = r_credit + CW'(accept && emit) - CW'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
            r_pend    <= '0;
            r_credit  <= '0;
            r_s_valid <= 1'b0;
            r_byp_hit <= 1'b0;
        end else begin
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
            r_pend    <= n_pend;
            r_credit  <= n_credit;
            r_s_valid <= accept && (!is_drain || drain_emit);
            r_byp_hit <= accept && wr_en && (r_s_addr == rd_addr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s_pix_op   <= !is_drain;
            r_s_emit     <= emit;
            r_s_addr     <= rd_addr;
            r_s_pix      <= i_pixel;
            r_s_sel_two  <= sel_two;
            r_s_interior <= interior && !is_drain;
            r_s_fe       <= fe;
        end
        r_byp_la  <= r_s_pix;
        r_byp_lta <= la_v;
    end

    // line stores: read at intake, written in the cycle after
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_la_q  <= r_la_mem[rd_addr];
            r_lta_q <= r_lta_mem[rd_addr];
        end
        if (wr_en) begin
            r_la_mem[r_s_addr]  <= r_s_pix;
            r_lta_mem[r_s_addr] <= la_v;
        end
    end

    assign la_v  = r_byp_hit ? r_byp_la  : r_la_q;
    assign lta_v = r_byp_hit ? r_byp_lta : r_lta_q;
    assign wr_en = r_s_valid && r_s_pix_op;

    always_comb begin
        for (int k = 0; k < WIN_N; k++) begin
            n_win[k] = r_win[k];
        end
        if (wr_en) begin
            for (int r = 0; r < 3; r++) begin
                n_win[3*r]     = r_win[3*r + 1];
                n_win[3*r + 1] = r_win[3*r + 2];
            end
            n_win[2] = lta_v;
            n_win[5] = la_v;
            n_win[8] = r_s_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < WIN_N; k++) begin
                r_win[k] <= '0;
            end
        end else begin
            for (int k = 0; k < WIN_N; k++) begin
                r_win[k] <= n_win[k];
            end
        end
    end

    always_comb begin
        o_push = r_s_valid && r_s_emit;
        o_rec  = '0;
        if (r_s_pix_op) begin
            for (int k = 0; k < WIN_N; k++) begin
                o_rec.win[k] = n_win[k];
            end
        end else begin
            o_rec.win[CENTRE] = r_s_sel_two ? lta_v : la_v;
        end
        o_rec.interior  = r_s_interior;
        o_rec.frame_end = r_s_fe;
    end

`ifndef SYNTHESIS
    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_credit <= CW'(Q_DEPTH))
        else $error("queue credit overrun");
    a_push_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> $past(accept && emit))
        else $error("record pushed without an emitting item");
    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        EW'(r_pend) <= W_MAX + EW'(1))
        else $error("pending count beyond one line plus one");
`endif

endmodule

/* sv/tmd_queue.sv */
// tmd_queue: short FIFO of window records between intake and median pipeline.
// Depends on tmd_pkg.
module tmd_queue import tmd_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_rec i_rec,
    input  logic i_pop,
    output logic o_valid,
    output t_rec o_rec
);

    localparam int QAW = $clog2(Q_DEPTH);
    localparam int CW  = $clog2(Q_DEPTH + 1);

    t_rec           r_mem [Q_DEPTH];
    logic [QAW-1:0] r_wp, r_rp;
    logic [CW-1:0]  r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + QAW'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + QAW'(1);
            end
            r_cnt <= r_cnt + CW'(i_push) - CW'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_rec;
        end
    end

    assign o_valid = (r_cnt != '0);
    assign o_rec   = r_mem[r_rp];

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == CW'(Q_DEPTH)) |-> !i_push)
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from empty queue");
    a_ptr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        QAW'(r_wp - r_rp) == r_cnt[QAW-1:0])
        else $error("queue pointers disagree with count");
`endif

endmodule

/* sv/tmd_back.sv */
// tmd_back: pipelined 3x3 median, threshold decision and output register.
// Depends on tmd_pkg.
module tmd_back import tmd_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  t_rec             i_q_rec,
    output logic             o_q_pop,
    input  logic [THR_W-1:0] i_threshold,
    input  logic             i_force,
    output logic             o_valid,
    input  logic             i_ready,
    output t_pix             o_pixel,
    output logic             o_frame_end,
    output logic             o_replaced
);

    logic r_b1_v, r_b2_v, r_b3_v, r_o_v;
    logic en1, en2, en3, en_o;

    t_tri r_b1_row [3];
    t_pix r_b1_c;
    logic r_b1_int, r_b1_fe;

    t_pix r_b2_mx, r_b2_md, r_b2_mn, r_b2_c;
    logic r_b2_int, r_b2_fe;

    t_pix r_b3_med, r_b3_c;
    logic r_b3_int, r_b3_fe;

    t_pix r_o_pix;
    logic r_o_fe, r_o_rep;

    logic signed [PIX_W+1:0] d_pos, d_neg, thr_x;
    logic                    rep;

    assign en_o    = !r_o_v || i_ready;
    assign en3     = !r_b3_v || en_o;
    assign en2     = !r_b2_v || en3;
    assign en1     = !r_b1_v || en2;
    assign o_q_pop = i_q_valid && en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_v <= 1'b0;
            r_b2_v <= 1'b0;
            r_b3_v <= 1'b0;
            r_o_v  <= 1'b0;
        end else begin
            if (en1) begin
                r_b1_v <= i_q_valid;
            end
            if (en2) begin
                r_b2_v <= r_b1_v;
            end
            if (en3) begin
                r_b3_v <= r_b2_v;
            end
            if (en_o) begin
                r_o_v <= r_b3_v;
            end
        end
    end

    // median of nine: sort rows, then max of lows, median of mids, min of highs
    always_ff @(posedge i_clk) begin
        if (en1) begin
            for (int r = 0; r < 3; r++) begin
                r_b1_row[r] <= sort3(i_q_rec.win[3*r], i_q_rec.win[3*r + 1],
                                     i_q_rec.win[3*r + 2]);
            end
            r_b1_c   <= i_q_rec.win[CENTRE];
            r_b1_int <= i_q_rec.interior;
            r_b1_fe  <= i_q_rec.frame_end;
        end
        if (en2) begin
            r_b2_mx  <= max3(r_b1_row[0].lo, r_b1_row[1].lo, r_b1_row[2].lo);
            r_b2_md  <= med3(r_b1_row[0].mid, r_b1_row[1].mid, r_b1_row[2].mid);
            r_b2_mn  <= min3(r_b1_row[0].hi, r_b1_row[1].hi, r_b1_row[2].hi);
            r_b2_c   <= r_b1_c;
            r_b2_int <= r_b1_int;
            r_b2_fe  <= r_b1_fe;
        end
        if (en3) begin
            r_b3_med <= med3(r_b2_mx, r_b2_md, r_b2_mn);
            r_b3_c   <= r_b2_c;
            r_b3_int <= r_b2_int;
            r_b3_fe  <= r_b2_fe;
        end
        if (en_o) begin
            r_o_pix <= rep ? r_b3_med : r_b3_c;
            r_o_fe  <= r_b3_fe;
            r_o_rep <= rep;
        end
    end

    always_comb begin
        d_pos = (PIX_W+2)'(r_b3_c) - (PIX_W+2)'(r_b3_med);
        d_neg = (PIX_W+2)'(r_b3_med) - (PIX_W+2)'(r_b3_c);
        thr_x = {2'b00, i_threshold};
        rep   = r_b3_int && (i_force || (d_pos > thr_x) || (d_neg > thr_x));
    end

    assign o_valid     = r_o_v;
    assign o_pixel     = r_o_pix;
    assign o_frame_end = r_o_fe;
    assign o_replaced  = r_o_rep;

endmodule

/* sv/threshold_median_despeckle.sv */
// threshold_median_despeckle: top level with APB registers, intake, queue, median back end.
// Depends on tmd_pkg, tmd_front, tmd_queue and tmd_back.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries i_op and i_pixel_value.
//   A pixel item (op 0) enters the raster stream; a drain item (op 1) flushes
//   one pending pixel unchanged, or does nothing when none is pending.
//   Output channel (o_out_valid / i_out_ready) carries o_pixel_out,
//   o_frame_end and o_replaced, in raster order, one line plus one pixel
//   behind the input stream.
//   Throughput: one item per cycle while queue credits remain. An emitting
//   item passes the intake register, the window update and queue write,
//   three median stages and the output register on its way to the output.
//   Registers (APB, byte address 4*i): frame_width, frame_height,
//   deviation_threshold, force_median. Write them only while idle.
//   Reset clears counters, window, queue and pipeline; the line stores hold
//   no reset value and need no clearing pass.
//   When the receiver stalls, results fill the median pipeline and a
//   four-entry queue; input is refused once the queue credits run out.
module threshold_median_despeckle import tmd_pkg::*; #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_op,
    input  t_pix              i_pixel_value,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_pix              o_pixel_out,
    output logic              o_frame_end,
    output logic              o_replaced
);

    logic [SIZE_W-1:0] r_frame_width, r_frame_height;
    logic [THR_W-1:0]  r_threshold;
    logic              r_force;

    logic cfg_wr;
    t_reg cfg_idx;

    logic q_push, q_pop, q_valid;
    t_rec f_rec, q_rec;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = t_reg'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= SIZE_W'(1024);
            r_frame_height <= SIZE_W'(1024);
            r_threshold    <= '0;
            r_force        <= 1'b0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_FRAME_WIDTH:  r_frame_width  <= pwdata[SIZE_W-1:0];
                REG_FRAME_HEIGHT: r_frame_height <= pwdata[SIZE_W-1:0];
                REG_THRESHOLD:    r_threshold    <= pwdata[THR_W-1:0];
                REG_FORCE:        r_force        <= pwdata[0];
                default:          r_force        <= r_force;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_FRAME_WIDTH:  prdata = APB_DW'(r_frame_width);
            REG_FRAME_HEIGHT: prdata = APB_DW'(r_frame_height);
            REG_THRESHOLD:    prdata = APB_DW'(r_threshold);
            REG_FORCE:        prdata = APB_DW'(r_force);
            default:          prdata = '0;
        endcase
    end

    tmd_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_in_valid),
        .o_ready        (o_in_ready),
        .i_op           (i_op),
        .i_pixel        (i_pixel_value),
        .i_frame_width  (r_frame_width),
        .i_frame_height (r_frame_height),
        .o_push         (q_push),
        .o_rec          (f_rec),
        .i_pop          (q_pop)
    );

    tmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_rec   (f_rec),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_rec   (q_rec)
    );

    tmd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_rec     (q_rec),
        .o_q_pop     (q_pop),
        .i_threshold (r_threshold),
        .i_force     (r_force),
        .o_valid     (o_out_valid),
        .i_ready     (i_out_ready),
        .o_pixel     (o_pixel_out),
        .o_frame_end (o_frame_end),
        .o_replaced  (o_replaced)
    );

endmodule

/* bench/threshold_median_despeckle_tb.sv */
`timescale 1ns / 100ps
// Testbench for threshold_median_despeckle: pixel frames through the despeckle filter.
// Results are checked against an in-bench prediction held in a scoreboard class.
// Depends on tmd_pkg and the threshold_median_despeckle RTL.
module threshold_median_despeckle_tb;
    import tmd_pkg::*;

    localparam int STORE_DEPTH   = 4096;
    localparam int MEDIAN_RANK   = 4;
    localparam int RANDOM_ITEMS  = 1000;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 300;

    typedef struct {
        t_pix pixel;
        logic frame_end;
        logic replaced;
    } t_filtered;

    class despeckle_scoreboard;
        int unsigned width_reg;
        int unsigned height_reg;
        int unsigned threshold_reg;
        int unsigned force_reg;
        t_pix above [STORE_DEPTH];
        t_pix two_above [STORE_DEPTH];
        t_pix win [WIN_N];
        int in_col, in_row, out_col, out_row;
        int backlog;
        int errors;
        t_filtered pending_pix [$];

        function new();
            width_reg     = 1024;
            height_reg    = 1024;
            threshold_reg = 0;
            force_reg     = 0;
            foreach (win[i]) win[i] = '0;
            foreach (above[i]) begin
                above[i]     = '0;
                two_above[i] = '0;
            end
            in_col  = 0;
            in_row  = 0;
            out_col = 0;
            out_row = 0;
            backlog = 0;
            errors  = 0;
        endfunction

        function void set_reg(t_reg r, int unsigned v);
            case (r)
                REG_FRAME_WIDTH:  width_reg = v & ((1 << SIZE_W) - 1);
                REG_FRAME_HEIGHT: height_reg = v & ((1 << SIZE_W) - 1);
                REG_THRESHOLD:    threshold_reg = v & ((1 << THR_W) - 1);
                REG_FORCE:        force_reg = v & 1;
                default: ;
            endcase
        endfunction

        function int eff_w();
            if (width_reg == 0) return 1;
            return (width_reg > STORE_DEPTH) ? STORE_DEPTH : width_reg;
        endfunction

        function int eff_h();
            if (height_reg == 0) return 1;
            return (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
        endfunction

        function int waiting();
            return pending_pix.size();
        endfunction

        function t_pix window_median();
            t_pix v [WIN_N];
            t_pix key;
            int j;
            v = win;
            for (int i = 1; i < WIN_N; i++) begin
                key = v[i];
                j = i - 1;
                while (j >= 0 && v[j] > key) begin
                    v[j + 1] = v[j];
                    j--;
                end
                v[j + 1] = key;
            end
            return v[MEDIAN_RANK];
        endfunction

        // accepted input item: update the model state, queue the pixel it releases
        function void take_item(logic op, t_pix pix);
            int w, h, col, dev;
            t_pix la, lta, value, med;
            t_filtered res;
            w = eff_w();
            h = eff_h();
            res.replaced = 1'b0;
            if (op == OP_DRAIN) begin
                if (backlog == 0) return;
                value = (backlog > w) ? two_above[out_col] : above[out_col];
                backlog--;
            end else begin
                col = in_col;
                la  = above[col];
                lta = two_above[col];
                two_above[col] = la;
                above[col]     = pix;
                for (int r = 0; r < 3; r++) begin
                    win[3*r]     = win[3*r + 1];
                    win[3*r + 1] = win[3*r + 2];
                end
                win[2] = lta;
                win[5] = la;
                win[8] = pix;
                in_col++;
                if (in_col >= w) begin
                    in_col = 0;
                    in_row++;
                    if (in_row >= h) in_row = 0;
                end
                if (backlog < w + 1) begin
                    backlog++;
                    return;
                end
                value = win[CENTRE];
                if (out_row >= 1 && out_row + 1 < h && out_col >= 1 && out_col + 1 < w) begin
                    med = window_median();
                    dev = int'(value) - int'(med);
                    if (dev < 0) dev = -dev;
                    if (force_reg != 0 || dev > int'(threshold_reg)) begin
                        value = med;
                        res.replaced = 1'b1;
                    end
                end
            end
            res.pixel     = value;
            res.frame_end = (out_col + 1 >= w && out_row + 1 >= h);
            out_col++;
            if (out_col >= w) begin
                out_col = 0;
                out_row++;
                if (out_row >= h) out_row = 0;
            end
            pending_pix.push_back(res);
        endfunction

        function void check_pixel(t_pix got_pix, logic got_end, logic got_repl);
            t_filtered want;
            if (pending_pix.size() == 0) begin
                errors++;
                $error("unexpected output item: pixel_out %0d", got_pix);
                return;
            end
            want = pending_pix.pop_front();
            if (got_pix !== want.pixel) begin
                errors++;
                $error("pixel_out: expected %0d, got %0d", want.pixel, got_pix);
            end
            if (got_end !== want.frame_end) begin
                errors++;
                $error("frame_end: expected %0b, got %0b", want.frame_end, got_end);
            end
            if (got_repl !== want.replaced) begin
                errors++;
                $error("replaced: expected %0b, got %0b", want.replaced, got_repl);
            end
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;
    logic              i_in_valid;
    logic              o_in_ready;
    logic              i_op;
    t_pix              i_pixel_value;
    logic              o_out_valid;
    logic              i_out_ready;
    t_pix              o_pixel_out;
    logic              o_frame_end;
    logic              o_replaced;

    despeckle_scoreboard sb = new();
    bit quiet = 1'b0;
    int hold_token = 0;
    int items_done = 0;

    // two 3x3 frames back to back: extremes with an outlier centre, then a flat ramp
    t_pix opening_px [18] = '{16'sh8000, 16'sh7fff, 16'sh0000,
                              16'sh0005, 16'sh8000, 16'sh0007,
                              16'sh7fff, 16'shffff, 16'sh0001,
                              16'sh0002, 16'sh0004, 16'sh0006,
                              16'sh0008, 16'sh000a, 16'sh000c,
                              16'sh000e, 16'sh0010, 16'sh0012};

    threshold_median_despeckle #(
        .MAX_WIDTH(STORE_DEPTH)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_op          (i_op),
        .i_pixel_value (i_pixel_value),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_pixel_out   (o_pixel_out),
        .o_frame_end   (o_frame_end),
        .o_replaced    (o_replaced)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    function automatic int gap_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 88) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // mostly a smooth background, with speckles and full-range noise
    function automatic t_pix speckled(input t_pix base);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 8) return t_pix'($urandom);
        if (roll < 12) return roll[0] ? 16'sh7fff : 16'sh8000;
        return base + t_pix'($urandom_range(0, 16)) - t_pix'(8);
    endfunction

    task automatic reg_write(input t_reg r, input int unsigned v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'(int'(r) * 4);
        pwdata  <= APB_DW'(v);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_reg(r, v);
    endtask

    task automatic set_frame(input int unsigned w, input int unsigned h,
                             input int unsigned thr, input int unsigned frc);
        reg_write(REG_FRAME_WIDTH, w);
        reg_write(REG_FRAME_HEIGHT, h);
        reg_write(REG_THRESHOLD, thr);
        reg_write(REG_FORCE, frc);
    endtask

    task automatic offer(input logic op, input t_pix pix);
        int gap;
        gap = quiet ? 0 : gap_len();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_op          <= op;
        i_pixel_value <= pix;
        do @(posedge i_clk); while (!o_in_ready);
        if (op == OP_PIXEL || sb.backlog != 0) items_done++;
        sb.take_item(op, pix);
    endtask

    task automatic wait_all();
        i_in_valid <= 1'b0;
        while (sb.waiting() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic flush();
        int n;
        n = sb.backlog;
        repeat (n) offer(OP_DRAIN, t_pix'($urandom));
        if ($urandom_range(0, 2) == 0) offer(OP_DRAIN, t_pix'($urandom));
        wait_all();
    endtask

    // whole frames plus an optional partial one; a partial frame is followed by
    // a 1x1 step that pulls the counters back to the frame origin
    task automatic run_phase(input int unsigned w, input int unsigned h,
                             input int unsigned thr, input int unsigned frc,
                             input int frames, input int extra);
        int total;
        t_pix base;
        set_frame(w, h, thr, frc);
        total = frames * sb.eff_w() * sb.eff_h() + extra;
        base = t_pix'($urandom);
        for (int i = 0; i < total; i++) begin
            if ($urandom_range(0, 99) < 3) offer(OP_DRAIN, t_pix'($urandom));
            if ($urandom_range(0, 199) == 0 && sb.waiting() != 0) begin
                i_in_valid <= 1'b0;
                while (sb.waiting() != 0) @(posedge i_clk);
            end
            offer(OP_PIXEL, speckled(base));
            base = base + t_pix'($urandom_range(0, 6)) - t_pix'(3);
        end
        flush();
        if (extra != 0) begin
            set_frame(1, 1, thr, frc);
            offer(OP_PIXEL, t_pix'($urandom));
            offer(OP_DRAIN, t_pix'($urandom));
            wait_all();
        end
    endtask

    task automatic random_phase();
        int unsigned w, h, thr, frc;
        int frames, extra, area, roll;
        roll = $urandom_range(0, 99);
        w = (roll < 4) ? 0 : (roll < 10) ? $urandom_range(13, 48) : $urandom_range(1, 12);
        h = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 8);
        roll = $urandom_range(0, 99);
        if (roll < 30) thr = $urandom_range(0, 20);
        else if (roll < 55) thr = 0;
        else if (roll < 75) thr = $urandom_range(0, 65535);
        else if (roll < 85) thr = 65535;
        else thr = $urandom_range(1, 200);
        frc = ($urandom_range(0, 3) == 0) ? 1 : 0;
        area = (w == 0 ? 1 : w) * (h == 0 ? 1 : h);
        frames = (area > 150) ? 1 : $urandom_range(1, 3);
        extra = (area > 1 && $urandom_range(0, 4) == 0) ? $urandom_range(1, area - 1) : 0;
        quiet = ($urandom_range(0, 4) == 0);
        run_phase(w, h, thr, frc, frames, extra);
    endtask

    // result side: random stalls, plus one long hold-off on request
    initial begin
        int stall;
        int seen;
        stall = 0;
        seen  = 0;
        i_out_ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (o_out_valid && i_out_ready)
                sb.check_pixel(o_pixel_out, o_frame_end, o_replaced);
            if (hold_token != seen) begin
                seen  = hold_token;
                stall = HOLD_CYCLES;
            end
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                stall--;
            end else begin
                i_out_ready <= 1'b1;
                if (!quiet && $urandom_range(0, 3) == 0) stall = gap_len();
            end
        end
    end

    initial begin
        int start;
        i_rst_n       <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        i_in_valid    <= 1'b0;
        i_op          <= OP_PIXEL;
        i_pixel_value <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: next frame without drain, early drain, drain with nothing pending
        set_frame(3, 3, 0, 0);
        for (int i = 0; i < 18; i++) begin
            if (i == 14) offer(OP_DRAIN, 16'sh7fff);
            offer(OP_PIXEL, opening_px[i]);
        end
        flush();
        offer(OP_DRAIN, 16'sh8000);
        wait_all();

        // size extremes: widest row, oversized width with zero height, oversized height
        run_phase(4096, 4096, 65535, 0, 0, 40);
        run_phase(8191, 0, 0, 1, 0, 30);
        run_phase(0, 8191, 100, 1, 0, 40);

        // receiver holds off while the sender keeps offering items
        quiet = 1'b1;
        hold_token++;
        run_phase(16, 8, 40, 0, 2, 0);
        quiet = 1'b0;

        start = items_done;
        while (items_done - start < RANDOM_ITEMS) random_phase();

        wait_all();
        if (sb.errors == 0 && sb.waiting() == 0) begin
            $display("threshold_median_despeckle: match");
        end else begin
            $display("threshold_median_despeckle: mismatch");
        end
        $finish;
    end

    initial begin
        #40ms;
        $display("threshold_median_despeckle: mismatch");
        $finish;
    end

endmodule

/* files.f */
sv/tmd_pkg.sv
sv/tmd_front.sv
sv/tmd_queue.sv
sv/tmd_back.sv
sv/threshold_median_despeckle.sv
bench/threshold_median_despeckle_tb.sv
